>>> hdl/gcc_pkg.sv
`default_nettype none
package gcc_pkg;

	localparam int unsigned MAX_COLUMNS_DEF  = 256;
	localparam int unsigned MAX_NONZEROS_DEF = 4096;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned IDX_W   = 13;
	localparam int unsigned VAL_W   = 13;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned COLOR_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_ROW_START  = 3'd0,
		OP_COL_INDEX  = 3'd1,
		OP_TROW_START = 3'd2,
		OP_TCOL_INDEX = 3'd3,
		OP_RUN        = 3'd4,
		OP_READ       = 3'd5
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // input word taken this cycle
		logic run_init;
		logic clr_step;   // clear one color flag
		logic rd_trs_lo;  // transposed row start at i (else i+1)
		logic lat_p;
		logic lat_pe;
		logic chk_j;      // take row number, fetch its start
		logic lat_q;
		logic lat_qe;
		logic chk_k;      // fetch color of column k
		logic mark;
		logic scan_init;
		logic scan_rd;
		logic scan_chk;
		logic fin;
		logic done;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic p_end;
		logic j_bad;
		logic q_end;
		logic k_stop;
		logic scan_last;
		logic col_last;
	} sts_t;

endpackage
`default_nettype wire

>>> hdl/gcc_ram.sv
`default_nettype none
module gcc_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a same-address write returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/gcc_ctrl.sv
`default_nettype none
module gcc_ctrl import gcc_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [OP_W-1:0] op,
	input  wire sts_t            sts,
	output cmd_t                 cmd,
	output logic                 busy
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_COL, ST_COLA, ST_COLB, ST_TRD, ST_TRW, ST_RA, ST_RB,
		ST_RD, ST_RW, ST_CW, ST_SCI, ST_SC, ST_SCW, ST_FIN, ST_DONE
	} state_t;

	state_t state_q;
	logic   acc;

	assign busy = (state_q != ST_IDLE);
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (acc && op == OP_RUN) state_q <= ST_CLR;
				ST_CLR:  if (sts.clr_last) state_q <= ST_COL;
				ST_COL:  state_q <= ST_COLA;
				ST_COLA: state_q <= ST_COLB;
				ST_COLB: state_q <= ST_TRD;
				ST_TRD:  state_q <= sts.p_end ? ST_SCI : ST_TRW;
				ST_TRW:  state_q <= sts.j_bad ? ST_TRD : ST_RA;
				ST_RA:   state_q <= ST_RB;
				ST_RB:   state_q <= ST_RD;
				ST_RD:   state_q <= sts.q_end ? ST_TRD : ST_RW;
				ST_RW:   state_q <= sts.k_stop ? ST_TRD : ST_CW;
				ST_CW:   state_q <= ST_RD;
				ST_SCI:  state_q <= ST_SC;
				ST_SC:   state_q <= ST_SCW;
				ST_SCW:  state_q <= sts.scan_last ? ST_FIN : ST_SC;
				ST_FIN:  state_q <= sts.col_last ? ST_DONE : ST_COL;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = acc;
		cmd.run_init  = acc && op == OP_RUN;
		cmd.clr_step  = (state_q == ST_CLR);
		cmd.rd_trs_lo = (state_q == ST_COL);
		cmd.lat_p     = (state_q == ST_COLA);
		cmd.lat_pe    = (state_q == ST_COLB);
		cmd.chk_j     = (state_q == ST_TRW);
		cmd.lat_q     = (state_q == ST_RA);
		cmd.lat_qe    = (state_q == ST_RB);
		cmd.chk_k     = (state_q == ST_RW);
		cmd.mark      = (state_q == ST_CW);
		cmd.scan_init = (state_q == ST_SCI);
		cmd.scan_rd   = (state_q == ST_SC);
		cmd.scan_chk  = (state_q == ST_SCW);
		cmd.fin       = (state_q == ST_FIN);
		cmd.done      = (state_q == ST_DONE);
	end

endmodule
`default_nettype wire

>>> hdl/gcc_dp.sv
`default_nettype none
module gcc_dp import gcc_pkg::*; #(
	parameter int unsigned MAX_COLUMNS  = MAX_COLUMNS_DEF,
	parameter int unsigned MAX_NONZEROS = MAX_NONZEROS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [IDX_W-1:0]   index,
	input  wire logic [VAL_W-1:0]   value,
	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   cfg_data,
	output logic                    strobe,
	output logic                    kind,
	output logic [COLOR_W-1:0]      color_value
);

	localparam int unsigned KW = $clog2(MAX_COLUMNS + 1);  // column, color
	localparam int unsigned CI = $clog2(MAX_COLUMNS);      // color store addr
	localparam int unsigned NA = $clog2(MAX_NONZEROS);     // entry addr
	localparam int unsigned PW = $clog2(MAX_NONZEROS + 1); // entry position

	logic [CNT_W-1:0] cfg_q;
	logic [KW-1:0]    n_eff, n_q, c_q, j_q, best_q, maxc_q, fcolor, run_n_q;
	logic [CI-1:0]    i_q;
	logic [PW-1:0]    p_q, pe_q, q_q, qe_q;
	logic             found_q, rd_pend_q, rd_zero_q, res_run_q;

	logic [PW-1:0] val_pos;
	logic [KW-1:0] val_col;
	logic          ld_rs, ld_ci, ld_trs, ld_tci, in_cols, in_nz;

	logic [PW-1:0] rs_rdata, trs_rdata;
	logic [KW-1:0] ci_rdata, tci_rdata, color_rdata, rs_raddr, trs_raddr;
	logic [CI-1:0] color_raddr;
	logic [KW-1:0] flag_waddr;
	logic          flag_rdata, flag_we;

	always_comb begin
		if (cfg_q == '0) begin
			n_eff = KW'(1);
		end else if (32'(cfg_q) > MAX_COLUMNS) begin
			n_eff = KW'(MAX_COLUMNS);
		end else begin
			n_eff = KW'(cfg_q);
		end
	end

	// stored values saturate: positions at MAX_NONZEROS, columns at MAX_COLUMNS
	assign val_pos = (32'(value) > MAX_NONZEROS) ? PW'(MAX_NONZEROS) : PW'(value);
	assign val_col = (32'(value) > MAX_COLUMNS) ? KW'(MAX_COLUMNS) : KW'(value);
	assign in_cols = 32'(index) < MAX_COLUMNS + 1;
	assign in_nz   = 32'(index) < MAX_NONZEROS;
	assign ld_rs   = cmd.accept && op == OP_ROW_START  && in_cols;
	assign ld_ci   = cmd.accept && op == OP_COL_INDEX  && in_nz;
	assign ld_trs  = cmd.accept && op == OP_TROW_START && in_cols;
	assign ld_tci  = cmd.accept && op == OP_TCOL_INDEX && in_nz;

	assign trs_raddr   = cmd.rd_trs_lo ? KW'(i_q) : KW'(i_q) + KW'(1);
	assign rs_raddr    = cmd.chk_j ? tci_rdata : j_q + KW'(1);
	assign color_raddr = cmd.chk_k ? CI'(ci_rdata) : CI'(index);
	assign flag_we     = cmd.clr_step || cmd.mark || cmd.scan_rd;
	assign flag_waddr  = cmd.mark ? color_rdata : c_q;
	assign fcolor      = found_q ? best_q : n_q;

	gcc_ram #(.WIDTH(PW), .DEPTH(MAX_COLUMNS + 1)) u_rs (
		.clk, .we(ld_rs), .waddr(KW'(index)), .wdata(val_pos),
		.raddr(rs_raddr), .rdata(rs_rdata));

	gcc_ram #(.WIDTH(KW), .DEPTH(MAX_NONZEROS)) u_ci (
		.clk, .we(ld_ci), .waddr(NA'(index)), .wdata(val_col),
		.raddr(NA'(q_q)), .rdata(ci_rdata));

	gcc_ram #(.WIDTH(PW), .DEPTH(MAX_COLUMNS + 1)) u_trs (
		.clk, .we(ld_trs), .waddr(KW'(index)), .wdata(val_pos),
		.raddr(trs_raddr), .rdata(trs_rdata));

	gcc_ram #(.WIDTH(KW), .DEPTH(MAX_NONZEROS)) u_tci (
		.clk, .we(ld_tci), .waddr(NA'(index)), .wdata(val_col),
		.raddr(NA'(p_q)), .rdata(tci_rdata));

	gcc_ram #(.WIDTH(KW), .DEPTH(MAX_COLUMNS)) u_color (
		.clk, .we(cmd.fin), .waddr(i_q), .wdata(fcolor),
		.raddr(color_raddr), .rdata(color_rdata));

	gcc_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS + 1)) u_flag (
		.clk, .we(flag_we), .waddr(flag_waddr), .wdata(cmd.mark),
		.raddr(c_q), .rdata(flag_rdata));

	assign sts.clr_last  = (c_q == n_q);
	assign sts.p_end     = (p_q >= pe_q);
	assign sts.j_bad     = (tci_rdata >= n_q);
	assign sts.q_end     = (q_q >= qe_q);
	assign sts.k_stop    = (ci_rdata >= KW'(i_q));
	assign sts.scan_last = (c_q == n_q);
	assign sts.col_last  = (KW'(i_q) + KW'(1) == n_q);

	// run_n_q: columns colored by the last run; the rest read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= CNT_W'(1);
			run_n_q   <= '0;
			rd_pend_q <= 1'b0;
			res_run_q <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_data;
			if (cmd.run_init) run_n_q <= n_eff;
			rd_pend_q <= cmd.accept && op == OP_READ;
			res_run_q <= cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		rd_zero_q <= !(32'(index) < 32'(n_eff) && 32'(index) < 32'(run_n_q));
		if (cmd.run_init) begin
			n_q    <= n_eff;
			i_q    <= '0;
			maxc_q <= '0;
			c_q    <= KW'(1);
		end
		if (cmd.clr_step) c_q  <= c_q + KW'(1);
		if (cmd.lat_p)    p_q  <= trs_rdata;
		if (cmd.lat_pe)   pe_q <= trs_rdata;
		if (cmd.chk_j) begin
			j_q <= tci_rdata;
			p_q <= p_q + PW'(1);
		end
		if (cmd.lat_q)  q_q  <= rs_rdata;
		if (cmd.lat_qe) qe_q <= rs_rdata;
		if (cmd.chk_k)  q_q  <= q_q + PW'(1);
		if (cmd.scan_init) begin
			c_q     <= KW'(1);
			found_q <= 1'b0;
		end
		if (cmd.scan_chk) begin
			if (!found_q && !flag_rdata && c_q < n_q) begin
				best_q  <= c_q;
				found_q <= 1'b1;
			end
			c_q <= c_q + KW'(1);
		end
		if (cmd.fin) begin
			if (fcolor > maxc_q) maxc_q <= fcolor;
			i_q <= i_q + CI'(1);
		end
	end

	assign strobe      = rd_pend_q || res_run_q;
	assign kind        = rd_pend_q;
	assign color_value = res_run_q ? COLOR_W'(maxc_q)
	                   : (rd_zero_q ? '0 : COLOR_W'(color_rdata));

endmodule
`default_nettype wire

>>> hdl/greedy_column_coloring_top.sv
`default_nettype none
// Channel    | Signals                          | Handshake
// -----------+----------------------------------+------------------------------------
// command    | start, busy, op, index, value    | taken on start && !busy
// config     | cfg_valid, cfg_ready, cfg_data   | written on cfg_valid && cfg_ready
// result     | strobe, kind, color_value        | one cycle per word, no backpressure
//
// Loads give no word; a load may follow every cycle while busy is low.
// A color read gives its word in the cycle after it is taken; reads also
// stream one per cycle while busy is low.
// A run holds busy while it clears the color flags; per column it reads the
// transposed row range, walks each listed row, marks the color of each entry
// until a column not below the current one ends the row, scans the flags for
// the lowest free color and stores it, in steps set by the single read port of
// each pattern memory; the run word appears in the first cycle with busy low.
// Reset (arst_n low) clears control and sets column_count to 1; the
// pattern memories hold nothing until loaded.
module greedy_column_coloring_top import gcc_pkg::*; #(
	parameter int unsigned MAX_COLUMNS  = MAX_COLUMNS_DEF,
	parameter int unsigned MAX_NONZEROS = MAX_NONZEROS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command words
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [IDX_W-1:0]   index,
	input  wire logic [VAL_W-1:0]   value,
	// column_count register
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CNT_W-1:0]   cfg_data,
	// result words
	output logic                    strobe,
	output logic                    kind,
	output logic [COLOR_W-1:0]      color_value
);

	cmd_t cmd;
	sts_t sts;

	// register only changes between runs
	assign cfg_ready = !busy;

	// sequencer: walks columns, rows and entries of the pattern
	gcc_ctrl u_ctrl (
		.clk, .arst_n, .start, .op, .sts, .cmd, .busy
	);

	// pattern memories, color store, used-color flags and counters
	gcc_dp #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_NONZEROS(MAX_NONZEROS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .op, .index, .value,
		.cfg_we(cfg_valid && cfg_ready), .cfg_data,
		.strobe, .kind, .color_value
	);

endmodule
`default_nettype wire

>>> hdl/gcc_checker.sv
`default_nettype none
module gcc_checker import gcc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [OP_W-1:0]    op,
	input wire logic               strobe,
	input wire logic               kind
);

	logic acc;
	assign acc = start && !busy;

	a_read_word: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == OP_READ |=> strobe && kind)
		else $error("read gave no color word");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == OP_RUN |=> busy && !strobe)
		else $error("run did not hold busy");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op != OP_READ && op != OP_RUN |=> !strobe)
		else $error("word after load or unused op");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && !kind)
		else $error("run ended without its word");

	a_run_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !kind |-> !busy && $past(busy))
		else $error("run word outside run end");

endmodule

bind greedy_column_coloring_top gcc_checker u_gcc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
	.strobe(strobe), .kind(kind)
);
`default_nettype wire
